### hdl/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/spq_pkg.sv
// Package: types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OCC_W = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DELETED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } out_word_t;
endpackage
`default_nettype wire

### hdl/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module spq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/sorted_priority_queue.sv
// Sorted max-priority queue: 64 signed 32-bit values held in one RAM.
//
// Channels: in (valid/stall) carries an in_word_t (func, value); out
// (valid/stall) carries an out_word_t (removed_value, status, occupancy).
// One result word per input word, in order.
// The list lives in a RAM with one write and one registered read port.
// Insert of value v into n stored values walks from the tail: each cycle
// reads entry i-1, and if it is not greater than v moves it to entry i,
// else writes v at entry i.
// Delete reads the head, then shifts every entry down by one, reading
// entry i+1 and writing entry i.
// Empty delete and full insert go straight to the result stage.
// One item is worked on at a time; in stays stalled until the result is
// loaded into the output register, so a new word is only taken once the
// result of the last one has been loaded.
// Reset empties the queue (count to zero) at once; RAM contents are left.
// While out stalls, the result waits in the output register; the next
// word is still taken and worked on, and its result then waits for the
// register to free, stalling in meanwhile.
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_data
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INS   = 5'b00010,
        S_DHEAD = 5'b00100,
        S_DSHFT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic signed [31:0]  val_reg, val_next;
    status_t             st_reg, st_next;
    out_word_t           res_reg, res_next;
    logic                ovalid_reg, ovalid_next;

    logic                we;
    logic [IDX_W-1:0]    waddr, raddr;
    logic [31:0]         wdata, rdata;
    logic [CNT_W-1:0]    ridx;

    spq_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign raddr     = ridx[IDX_W-1:0];
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = res_reg;

    // Sequencer: walk the list one RAM access per cycle
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        st_next     = st_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && out_stall;
        we          = 1'b0;
        waddr       = idx_reg[IDX_W-1:0];
        wdata       = val_reg;
        ridx        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ridx = count_reg - CNT_W'(1);
                if (in_valid)
                begin
                    val_next = in_data.value;
                    if (in_data.func == FUNC_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = count_reg;
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = '0;
                            ridx = '0;
                            state_next = S_DHEAD;
                        end
                    end
                end
            end
            S_INS:
            begin
                // rdata holds entry idx-1 when idx > 0
                we = 1'b1;
                if (idx_reg != '0 && !($signed(rdata) > val_reg))
                begin
                    wdata    = rdata;
                    idx_next = idx_reg - CNT_W'(1);
                    ridx     = idx_reg - CNT_W'(2);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    st_next = ST_INSERTED;
                    state_next = S_OUT;
                end
            end
            S_DHEAD:
            begin
                // head value kept in val_reg until the result goes out
                val_next = rdata;
                ridx = CNT_W'(1);
                state_next = S_DSHFT;
            end
            S_DSHFT:
            begin
                // rdata holds entry idx+1
                if (idx_reg + CNT_W'(1) < count_reg)
                begin
                    we       = 1'b1;
                    wdata    = rdata;
                    idx_next = idx_reg + CNT_W'(1);
                    ridx     = idx_reg + CNT_W'(2);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    st_next = ST_DELETED;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // load the result once the output register is free
                if (!ovalid_reg || !out_stall)
                begin
                    res_next.removed_value = (st_reg == ST_DELETED) ? val_reg : '0;
                    res_next.status = st_reg;
                    res_next.occupancy = OCC_W'(count_reg);
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end
endmodule
`default_nettype wire

### hdl/spq_checker.sv
// Port-level checker for the sorted priority queue, with its bind.
`default_nettype none
`include "sorted_priority_queue_defines.svh"
module spq_checker
    import spq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_word_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_data
);
    logic in_wait, in_take, out_wait, out_not_del, out_full;

    // Handshake and status terms
    assign in_wait     = in_valid && in_stall;
    assign in_take     = in_valid && !in_stall;
    assign out_wait    = out_valid && out_stall;
    assign out_not_del = out_valid && (out_data.status != ST_DELETED);
    assign out_full    = out_valid && (out_data.status == ST_FULL);

    `SPQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))
    `SPQ_ASSERT_NXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_data))
    `SPQ_ASSERT_IMP(a_rm_zero, clk, rst_n, out_not_del, out_data.removed_value == '0)
    `SPQ_ASSERT_IMP(a_full_occ, clk, rst_n, out_full, out_data.occupancy == OCC_W'(CAPACITY))
    `SPQ_ASSERT_NXT(a_in_busy, clk, rst_n, in_take, in_stall)
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
`default_nettype wire
